@@ rtl/dbc_pkg.sv @@
// Shared constants, types and segment decode for the debounced button counter display
`timescale 1ns / 1ps

package dbc_pkg;

  // sizes
  localparam int NUM_BUTTONS      = 8;
  localparam int DEBOUNCE_SAMPLES = 12;
  localparam int HIST_W           = DEBOUNCE_SAMPLES + 1;
  localparam int LEVEL_W          = 8;
  localparam int COUNT_W          = 14;
  localparam int SEG_W            = 8;
  localparam int SEL_W            = 3;

  // reset value of the count limit register
  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(1023);

  // history value that marks one released sample followed by a full pressed run
  localparam logic [HIST_W-1:0] HIST_MATCH = HIST_W'(1) << DEBOUNCE_SAMPLES;

  // reciprocal constants for the digit split
  localparam int unsigned RECIP_1000   = 8389;  // 2^23 / 1000, rounded up
  localparam int          RECIP_1000_SH = 23;
  localparam int unsigned RECIP_100    = 41;    // 2^12 / 100, rounded up
  localparam int          RECIP_100_SH = 12;
  localparam int unsigned RECIP_10     = 103;   // 2^10 / 10, rounded up
  localparam int          RECIP_10_SH  = 10;

  // scan positions and the matching digit-select codes
  localparam logic [SEL_W-1:0] POS_THOUSANDS = 3'd0;
  localparam logic [SEL_W-1:0] POS_HUNDREDS  = 3'd1;
  localparam logic [SEL_W-1:0] POS_COLON     = 3'd2;
  localparam logic [SEL_W-1:0] POS_TENS      = 3'd3;
  localparam logic [SEL_W-1:0] POS_ONES      = 3'd4;

  localparam logic [SEL_W-1:0] SEL_THOUSANDS = 3'd4;
  localparam logic [SEL_W-1:0] SEL_HUNDREDS  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_COLON     = 3'd2;
  localparam logic [SEL_W-1:0] SEL_TENS      = 3'd1;
  localparam logic [SEL_W-1:0] SEL_ONES      = 3'd0;

  localparam logic [SEG_W-1:0] SEG_DARK = 8'hFF;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [SEL_W-1:0]   sel_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [3:0]         digit_t;

  // active-low seven-segment pattern of one decimal digit
  function automatic seg_t seg_of(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_DARK;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/dbc_in_if.sv @@
// Button sample channel: valid, ready and the raw button levels
`timescale 1ns / 1ps

interface dbc_in_if;
  logic             valid;
  logic             ready;
  dbc_pkg::level_t  button_levels;

  modport source (output valid, output button_levels, input ready);
  modport sink   (input valid, input button_levels, output ready);
endinterface

@@ rtl/dbc_out_if.sv @@
// Display channel: valid, ready, segment pattern, digit select and count
`timescale 1ns / 1ps

interface dbc_out_if;
  logic             valid;
  logic             ready;
  dbc_pkg::seg_t    segment_pattern;
  dbc_pkg::sel_t    digit_select;
  dbc_pkg::count_t  count_value;

  modport source (output valid, output segment_pattern, output digit_select,
                  output count_value, input ready);
  modport sink   (input valid, input segment_pattern, input digit_select,
                  input count_value, output ready);
endinterface

@@ rtl/debounced_button_counter_display.sv @@
// Top level: button debounce, running count, digit split and display scan
`timescale 1ns / 1ps

// Debounced button counter with a five-position multiplexed display.
// in_beat carries one tick of eight active-low button levels. Each button has
// a shift register; one released sample followed by twelve pressed samples
// gives a pulse, and a pulse on button n adds 128>>n to the running count.
// A count above the limit register wraps to zero. out_beat returns one beat
// per tick: the active-low segment pattern of the next scan position
// (thousands, hundreds, colon, tens, ones, in turn), its digit-select code and
// the count after this tick. Leading zeros are blanked; the colon is dark.
// cfg_wr_en/cfg_wr_data write the 14-bit count limit; write it only when idle.
// Throughput: one tick per cycle while in_beat.ready is high. The count
// update (history shift, add and limit compare) is the one feedback loop;
// the digit split behind it is a seven-register pipeline. Each stage holds
// its beat while the next one is full, so a stalled receiver backs the
// pipeline up one stage at a time and in_beat.ready drops only when every
// stage is occupied.
// Reset clears the histories, the count and the scan position, loads the
// limit with 1023 and empties the pipeline.
module debounced_button_counter_display (
  input  logic                      clk,
  input  logic                      rst_n,
  dbc_in_if.sink                    in_beat,
  dbc_out_if.source                 out_beat,
  input  logic                      cfg_wr_en,
  input  logic [dbc_pkg::COUNT_W-1:0] cfg_wr_data
);
  import dbc_pkg::*;

  localparam int NSTG = 6;

  // pipeline control
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;
  logic            out_valid_r;
  logic            rdy_out;
  logic            in_fire;

  // state
  logic [HIST_W-1:0] hist_r [NUM_BUTTONS];
  logic [HIST_W-1:0] hist_nxt [NUM_BUTTONS];
  count_t            count_r;
  count_t            count_nxt;
  sel_t              scan_r;
  sel_t              scan_nxt;
  count_t            limit_r;

  // stage payloads
  count_t            s1_count_r, s2_count_r, s3_count_r, s4_count_r, s5_count_r, s6_count_r;
  sel_t              s1_pos_r, s2_pos_r, s3_pos_r, s4_pos_r, s5_pos_r, s6_pos_r;
  logic [4:0]        s2_q_r;
  digit_t            s3_th_r, s4_th_r, s5_th_r, s6_th_r;
  logic [9:0]        s3_rem_r, s4_rem_r;
  digit_t            s4_hu_r, s5_hu_r, s6_hu_r;
  logic [6:0]        s5_rem_r, s6_rem_r;
  digit_t            s6_te_r;

  seg_t              seg_r;
  sel_t              sel_r;
  count_t            cnt_out_r;

  // stage arithmetic
  logic [27:0]       q1000_prod;
  digit_t            th_nxt;
  logic [9:0]        rem1000_nxt;
  logic [15:0]       q100_prod;
  logic [6:0]        rem100_nxt;
  logic [13:0]       q10_prod;
  digit_t            on_nxt;
  seg_t              seg_nxt;
  sel_t              sel_nxt;
  logic              blank_th, blank_hu, blank_te;

  logic [COUNT_W:0]  sum;

  // ready chain: a stage can load when empty or when it drains this cycle
  assign rdy_out = !out_valid_r || out_beat.ready;
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || rdy_out;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_beat.ready = rdy[0];
  assign in_fire       = in_beat.valid && in_beat.ready;

  // debounce histories, pulse sum and limit wrap
  always_comb begin
    sum = {1'b0, count_r};
    for (int n = 0; n < NUM_BUTTONS; n++) begin
      hist_nxt[n] = {hist_r[n][HIST_W-2:0], in_beat.button_levels[n]};
      if (hist_nxt[n] == HIST_MATCH) begin
        sum = sum + (COUNT_W+1)'(8'd128 >> n);
      end
    end
    if (sum > {1'b0, limit_r}) begin
      count_nxt = '0;
    end else begin
      count_nxt = sum[COUNT_W-1:0];
    end
    if (scan_r >= POS_ONES) begin
      scan_nxt = POS_THOUSANDS;
    end else begin
      scan_nxt = scan_r + 3'd1;
    end
  end

  // state registers: histories, count and scan update once per accepted beat, the limit on cfg_wr_en
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NUM_BUTTONS; n++) begin
        hist_r[n] <= '0;
      end
      count_r <= '0;
      scan_r  <= POS_THOUSANDS;
      limit_r <= LIMIT_RESET;
    end else begin
      if (in_fire) begin
        for (int n = 0; n < NUM_BUTTONS; n++) begin
          hist_r[n] <= hist_nxt[n];
        end
        count_r <= count_nxt;
        scan_r  <= scan_nxt;
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_beat.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (rdy_out) begin
        out_valid_r <= v_r[NSTG-1];
      end
    end
  end

  // digit split arithmetic
  always_comb begin
    q1000_prod  = 28'(s1_count_r) * 28'(RECIP_1000);
    th_nxt      = (s2_q_r >= 5'd10) ? 4'(s2_q_r - 5'd10) : 4'(s2_q_r);
    rem1000_nxt = 10'(s2_count_r - COUNT_W'(s2_q_r) * COUNT_W'(1000));
    q100_prod   = 16'(s3_rem_r) * 16'(RECIP_100);
    rem100_nxt  = 7'(s4_rem_r - 10'(s4_hu_r) * 10'(100));
    q10_prod    = 14'(s5_rem_r) * 14'(RECIP_10);
    on_nxt      = 4'(s6_rem_r - 7'(s6_te_r) * 7'(10));
  end

  // blanking and selection of the scanned position
  always_comb begin
    blank_th = (s6_th_r == 4'd0);
    blank_hu = blank_th && (s6_hu_r == 4'd0);
    blank_te = blank_hu && (s6_te_r == 4'd0);
    case (s6_pos_r)
      POS_THOUSANDS: begin
        seg_nxt = blank_th ? SEG_DARK : seg_of(s6_th_r);
        sel_nxt = SEL_THOUSANDS;
      end
      POS_HUNDREDS: begin
        seg_nxt = blank_hu ? SEG_DARK : seg_of(s6_hu_r);
        sel_nxt = SEL_HUNDREDS;
      end
      POS_COLON: begin
        seg_nxt = SEG_DARK;
        sel_nxt = SEL_COLON;
      end
      POS_TENS: begin
        seg_nxt = blank_te ? SEG_DARK : seg_of(s6_te_r);
        sel_nxt = SEL_TENS;
      end
      POS_ONES: begin
        seg_nxt = seg_of(on_nxt);
        sel_nxt = SEL_ONES;
      end
      default: begin
        seg_nxt = SEG_DARK;
        sel_nxt = SEL_THOUSANDS;
      end
    endcase
  end

  // pipeline payload registers
  always_ff @(posedge clk) begin
    if (rdy[0] && in_beat.valid) begin
      s1_count_r <= count_nxt;
      s1_pos_r   <= scan_r;
    end
    if (rdy[1] && v_r[0]) begin
      s2_count_r <= s1_count_r;
      s2_pos_r   <= s1_pos_r;
      s2_q_r     <= q1000_prod[RECIP_1000_SH +: 5];
    end
    if (rdy[2] && v_r[1]) begin
      s3_count_r <= s2_count_r;
      s3_pos_r   <= s2_pos_r;
      s3_th_r    <= th_nxt;
      s3_rem_r   <= rem1000_nxt;
    end
    if (rdy[3] && v_r[2]) begin
      s4_count_r <= s3_count_r;
      s4_pos_r   <= s3_pos_r;
      s4_th_r    <= s3_th_r;
      s4_rem_r   <= s3_rem_r;
      s4_hu_r    <= q100_prod[RECIP_100_SH +: 4];
    end
    if (rdy[4] && v_r[3]) begin
      s5_count_r <= s4_count_r;
      s5_pos_r   <= s4_pos_r;
      s5_th_r    <= s4_th_r;
      s5_hu_r    <= s4_hu_r;
      s5_rem_r   <= rem100_nxt;
    end
    if (rdy[5] && v_r[4]) begin
      s6_count_r <= s5_count_r;
      s6_pos_r   <= s5_pos_r;
      s6_th_r    <= s5_th_r;
      s6_hu_r    <= s5_hu_r;
      s6_rem_r   <= s5_rem_r;
      s6_te_r    <= q10_prod[RECIP_10_SH +: 4];
    end
    if (rdy_out && v_r[NSTG-1]) begin
      seg_r     <= seg_nxt;
      sel_r     <= sel_nxt;
      cnt_out_r <= s6_count_r;
    end
  end

  // output beat
  assign out_beat.valid           = out_valid_r;
  assign out_beat.segment_pattern = seg_r;
  assign out_beat.digit_select    = sel_r;
  assign out_beat.count_value     = cnt_out_r;

  // scan position never leaves the five display positions
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r <= POS_ONES)
    else $error("scan position out of range");

  // an accepted beat always lands in the first stage
  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v_r[0])
    else $error("accepted beat lost at first stage");

  // colon position is always dark
  a_colon_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (sel_r == SEL_COLON)) |-> (seg_r == SEG_DARK))
    else $error("colon position not dark");

  // a stalled result holds its count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_beat.ready) |=> (out_valid_r && $stable(cnt_out_r)))
    else $error("stalled result changed");

endmodule

@@ tb/sv/debounced_button_counter_display_tb.sv @@
// Testbench for the debounced button counter display: random ticks, stalls and limit settings
`timescale 1ns / 1ps

module debounced_button_counter_display_tb;
  import dbc_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 12;
  localparam int MAX_IDLE    = 16;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [COUNT_W-1:0] LIMIT_MAX = '1;

  typedef struct packed {
    seg_t   seg;
    sel_t   sel;
    count_t cnt;
  } display_beat_t;

  // display model: debounce, count, digit split and scan, with its queue of beats
  class display_scoreboard;
    logic [HIST_W-1:0] history [NUM_BUTTONS];
    count_t            count;
    count_t            limit;
    sel_t              scan;
    display_beat_t     expected_beats [$];
    int                errors;

    function new();
      foreach (history[n]) history[n] = '0;
      count  = '0;
      limit  = LIMIT_RESET;
      scan   = POS_THOUSANDS;
      errors = 0;
    endfunction

    function void set_limit(count_t v);
      limit = v;
    endfunction

    function seg_t glyph(int unsigned d);
      case (d)
        0:       return 8'hC0;
        1:       return 8'hF9;
        2:       return 8'hA4;
        3:       return 8'hB0;
        4:       return 8'h99;
        5:       return 8'h92;
        6:       return 8'h82;
        7:       return 8'hF8;
        8:       return 8'h80;
        default: return 8'h90;
      endcase
    endfunction

    // one tick in: shift histories, add pulses, wrap, pick the scanned position
    function void note_tick(level_t lv);
      int unsigned   sum;
      int unsigned   th, hu, te, on;
      seg_t          seg_th, seg_hu, seg_te, seg_on;
      display_beat_t b;
      sum = count;
      for (int n = 0; n < NUM_BUTTONS; n++) begin
        history[n] = {history[n][HIST_W-2:0], lv[n]};
        if (history[n] == HIST_MATCH) sum += 128 >> n;
      end
      if (sum > limit) sum = 0;
      count = count_t'(sum);

      th = (count / 1000) % 10;
      hu = (count / 100) % 10;
      te = (count / 10) % 10;
      on = count % 10;
      seg_th = glyph(th);
      seg_hu = glyph(hu);
      seg_te = glyph(te);
      seg_on = glyph(on);
      // leading-zero blanking, ones always lit
      if (th == 0) begin
        seg_th = SEG_DARK;
        if (hu == 0) begin
          seg_hu = SEG_DARK;
          if (te == 0) seg_te = SEG_DARK;
        end
      end

      case (scan)
        POS_THOUSANDS: begin b.seg = seg_th;   b.sel = SEL_THOUSANDS; end
        POS_HUNDREDS:  begin b.seg = seg_hu;   b.sel = SEL_HUNDREDS;  end
        POS_COLON:     begin b.seg = SEG_DARK; b.sel = SEL_COLON;     end
        POS_TENS:      begin b.seg = seg_te;   b.sel = SEL_TENS;      end
        default:       begin b.seg = seg_on;   b.sel = SEL_ONES;      end
      endcase
      b.cnt = count;
      expected_beats.push_back(b);
      scan = (scan == POS_ONES) ? POS_THOUSANDS : scan + 1'b1;
    endfunction

    // one display beat out: compare with the oldest expectation
    function void check_beat(seg_t seg, sel_t sel, count_t cnt);
      display_beat_t b;
      if (expected_beats.size() == 0) begin
        $error("unexpected display beat: seg %h sel %0d count %0d", seg, sel, cnt);
        errors++;
        return;
      end
      b = expected_beats.pop_front();
      if (seg !== b.seg) begin
        $error("segment_pattern: expected %h, got %h", b.seg, seg);
        errors++;
      end
      if (sel !== b.sel) begin
        $error("digit_select: expected %0d, got %0d", b.sel, sel);
        errors++;
      end
      if (cnt !== b.cnt) begin
        $error("count_value: expected %0d, got %0d", b.cnt, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;
  int   cycles;
  bit   in_fast;
  bit   out_fast;

  display_scoreboard sb = new();

  dbc_in_if  in_beat ();
  dbc_out_if out_beat ();

  debounced_button_counter_display dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_beat     (in_beat),
    .out_beat    (out_beat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // accepted beats on both channels
  always @(posedge clk) begin
    if (rst_n && in_beat.valid && in_beat.ready) sb.note_tick(in_beat.button_levels);
    if (rst_n && out_beat.valid && out_beat.ready)
      sb.check_beat(out_beat.segment_pattern, out_beat.digit_select, out_beat.count_value);
  end

  // one tick beat, after a random gap
  task automatic send_tick(level_t lv);
    int gap;
    if ($urandom_range(0, 39) == 0) in_fast = !in_fast;
    gap = in_fast ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    if (gap > 0) begin
      in_beat.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_beat.valid         = 1'b1;
    in_beat.button_levels = lv;
    do @(posedge clk); while (!in_beat.ready);
  endtask

  // let the pipeline drain before touching the limit or finishing
  task automatic drain();
    @(negedge clk);
    in_beat.valid = 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(count_t v);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_limit(v);
  endtask

  // press bursts: one released sample, then a pressed run, with noise and glitches
  task automatic run_phase(int n_ticks, bit heavy);
    int     sent;
    int     run_len;
    int     glitch_at;
    level_t mask;
    level_t lv;
    sent = 0;
    while (sent < n_ticks) begin
      if (!heavy && $urandom_range(0, 9) == 0) begin
        send_tick(level_t'($urandom));
        sent++;
      end else begin
        if (heavy) begin
          mask    = ($urandom_range(0, 9) != 0) ? 8'hFF : level_t'($urandom);
          run_len = $urandom_range(DEBOUNCE_SAMPLES, DEBOUNCE_SAMPLES + 2);
        end else begin
          mask    = level_t'($urandom);
          run_len = $urandom_range(DEBOUNCE_SAMPLES - 1, DEBOUNCE_SAMPLES + 2);
        end
        glitch_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, run_len - 1) : -1;
        send_tick(mask | (level_t'($urandom) & ~mask));
        sent++;
        for (int t = 0; t < run_len; t++) begin
          lv = level_t'($urandom) & ~mask;
          if (t == glitch_at) lv = lv | (mask & level_t'($urandom));
          send_tick(lv);
          sent++;
        end
      end
    end
  endtask

  // result side: random stalls
  initial begin
    int stall;
    out_beat.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_fast = !out_fast;
      stall = out_fast ? 0 : $urandom_range(0, MAX_IDLE);
      @(negedge clk);
      if (stall > 0) begin
        out_beat.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_beat.ready = 1'b1;
      do @(posedge clk); while (!out_beat.valid);
    end
  end

  // stimulus
  initial begin
    level_t tail [6] = '{8'hFF, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'hFE};
    cycles                = 0;
    in_fast               = 1'b0;
    out_fast              = 1'b0;
    rst_n                 = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    in_beat.valid         = 1'b0;
    in_beat.button_levels = '0;
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // buttons held from reset give nothing until released once
    repeat (3) send_tick(8'h00);
    send_tick(8'hFF);
    // every button pulses on the same tick
    repeat (DEBOUNCE_SAMPLES) send_tick(8'h00);
    foreach (tail[i]) send_tick(tail[i]);

    run_phase(250, 1'b0);
    write_limit('0);
    run_phase(120, 1'b0);
    write_limit(COUNT_W'(9999));
    run_phase(380, 1'b1);
    // limit above the display range, so the count passes 9999 and wraps
    write_limit(LIMIT_MAX);
    run_phase(900, 1'b1);
    write_limit(COUNT_W'($urandom_range(1, 9998)));
    run_phase(280, 1'b0);

    drain();
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
